>>> rtl/core/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types, constants and character/key tables for the keypad scanner
// and seven-segment display block.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int NUM_COLUMNS = 4;
  localparam int NUM_ROWS    = 4;
  localparam int COL_W       = $clog2(NUM_COLUMNS);

  typedef enum logic [1:0] {
    KS_BUSY  = 2'd0,
    KS_NOKEY = 2'd1,
    KS_ONE   = 2'd2,
    KS_MULTI = 2'd3
  } key_status_t;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_SCAN = 1'b1
  } op_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic [3:0] row_bits;
  } kpd_item_t;

  typedef struct packed {
    logic [3:0] column_select;
    logic [7:0] segment_pattern;
    logic [1:0] key_status;
    logic [6:0] key_code;
  } kpd_result_t;

  // scan unit -> top: column to drive next and the key report
  typedef struct packed {
    logic [COL_W-1:0] column;
    key_status_t      status;
    logic [6:0]       code;
  } kpd_scan_res_t;

  // power-up message "PEtE"
  localparam logic [7:0] RESET_DIGITS [NUM_COLUMNS] = '{8'h73, 8'h79, 8'h78, 8'h79};

  localparam logic [7:0] HEX_SEGS [17] = '{
    8'h00, 8'h06, 8'h5B, 8'h4F, 8'h71, 8'h66, 8'h6D, 8'h7D, 8'h79,
    8'h07, 8'h7F, 8'h6F, 8'h5E, 8'h77, 8'h3F, 8'h7C, 8'h39};
  localparam logic [7:0] NUM_SEGS [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
  localparam logic [7:0] UPPER_SEGS [26] = '{
    8'h77, 8'h7F, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F, 8'h76, 8'h30,
    8'h1E, 8'h76, 8'h38, 8'h15, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50,
    8'h6D, 8'h78, 8'h3E, 8'h1C, 8'h2A, 8'h76, 8'h6E, 8'h5B};
  localparam logic [7:0] LOWER_SEGS [26] = '{
    8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h6F, 8'h74, 8'h04,
    8'h1E, 8'h76, 8'h38, 8'h15, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50,
    8'h6D, 8'h78, 8'h3E, 8'h1C, 8'h2A, 8'h76, 8'h6E, 8'h5B};

  // ASCII, indexed [row*4 + column]
  localparam logic [6:0] KEY_MAP [16] = '{
    7'h31, 7'h32, 7'h33, 7'h46,
    7'h34, 7'h35, 7'h36, 7'h45,
    7'h37, 7'h38, 7'h39, 7'h44,
    7'h41, 7'h30, 7'h42, 7'h43};

  function automatic logic [7:0] encode_char(input logic [7:0] ch);
    logic [7:0] seg;
    logic [7:0] ofs;
    ofs = 8'h00;
    seg = 8'h00;
    case (ch) inside
      8'h20:                      seg = 8'h00;
      8'h2D:                      seg = 8'h40;
      8'h2E:                      seg = 8'h80;
      8'h3D:                      seg = 8'h48;
      8'h3F:                      seg = 8'h83;
      8'h21:                      seg = 8'h82;
      8'h5F:                      seg = 8'h08;
      8'h28, 8'h3C, 8'h5B, 8'h7B: seg = 8'h39;
      8'h29, 8'h3E, 8'h5D, 8'h7D: seg = 8'h0F;
      [8'h00:8'h10]:              seg = HEX_SEGS[ch[4:0]];
      [8'h30:8'h39]: begin
        ofs = ch - 8'h30;
        seg = NUM_SEGS[ofs[3:0]];
      end
      [8'h41:8'h5A]: begin
        ofs = ch - 8'h41;
        seg = UPPER_SEGS[ofs[4:0]];
      end
      [8'h61:8'h7A]: begin
        ofs = ch - 8'h61;
        seg = LOWER_SEGS[ofs[4:0]];
      end
      default:                    seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

>>> rtl/core/kpd_channels.sv
// ----------------------------------------------------------------------------
// kpd channels
// Valid/ready channel interfaces for scan/character items and results.
// ----------------------------------------------------------------------------
interface kpd_in_if import kpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] char_code;
  logic [3:0] row_bits;

  modport source (output valid, operation, char_code, row_bits, input ready);
  modport sink   (input valid, operation, char_code, row_bits, output ready);
endinterface

interface kpd_out_if import kpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] column_select;
  logic [7:0] segment_pattern;
  logic [1:0] key_status;
  logic [6:0] key_code;

  modport source (output valid, column_select, segment_pattern, key_status, key_code,
                  input ready);
  modport sink   (input valid, column_select, segment_pattern, key_status, key_code,
                  output ready);
endinterface

>>> rtl/core/kpd_scan.sv
// ----------------------------------------------------------------------------
// kpd_scan
// Column counter, press counter and last-key register; reports the key
// status at the end of each pass over the columns.
// ----------------------------------------------------------------------------
module kpd_scan import kpd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  kpd_item_t     item,
  output kpd_scan_res_t res
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [6:0]       key_r, key_nxt;

  logic [2:0] hits;
  logic [2:0] sum;
  logic [1:0] cnt_sat;
  logic [6:0] key_seen;
  logic       last_col;

  always_comb begin
    hits     = 3'd0;
    key_seen = key_r;
    // highest pressed row wins
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (item.row_bits[r]) begin
        hits     = hits + 3'd1;
        key_seen = KEY_MAP[{2'(r), col_r}];
      end
    end
    sum      = {1'b0, cnt_r} + hits;
    cnt_sat  = (sum >= 3'd2) ? 2'd2 : sum[1:0];
    last_col = (col_r == COL_W'(NUM_COLUMNS - 1));

    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    res.status = KS_BUSY;
    res.code   = 7'd0;

    if (item.operation == OP_SCAN) begin
      col_nxt = col_r + COL_W'(1);
      if (last_col) begin
        cnt_nxt = 2'd0;
        key_nxt = 7'd0;
        case (cnt_sat)
          2'd0:    res.status = KS_NOKEY;
          2'd1: begin
            res.status = KS_ONE;
            res.code   = key_seen;
          end
          default: res.status = KS_MULTI;
        endcase
      end else begin
        cnt_nxt = cnt_sat;
        key_nxt = key_seen;
      end
    end
    res.column = col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      cnt_r <= 2'd0;
      key_r <= 7'd0;
    end else if (accept) begin
      col_r <= col_nxt;
      cnt_r <= cnt_nxt;
      key_r <= key_nxt;
    end
  end

endmodule

>>> rtl/core/kpd_display.sv
// ----------------------------------------------------------------------------
// kpd_display
// Four digit pattern registers; a character shifts in from the right.
// Gives the pattern of the requested column after the update.
// ----------------------------------------------------------------------------
module kpd_display import kpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  kpd_item_t        item,
  input  logic [COL_W-1:0] column,
  output logic [7:0]       segments
);

  logic [7:0] dig_r   [NUM_COLUMNS];
  logic [7:0] dig_nxt [NUM_COLUMNS];

  always_comb begin
    for (int i = 0; i < NUM_COLUMNS; i++) begin
      dig_nxt[i] = dig_r[i];
    end
    if (item.operation == OP_CHAR) begin
      for (int i = 0; i < NUM_COLUMNS - 1; i++) begin
        dig_nxt[i] = dig_r[i+1];
      end
      dig_nxt[NUM_COLUMNS-1] = encode_char(item.char_code);
    end
    segments = dig_nxt[column];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        dig_r[i] <= RESET_DIGITS[i];
      end
    end else if (accept) begin
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        dig_r[i] <= dig_nxt[i];
      end
    end
  end

endmodule

>>> rtl/core/kpd_out_buf.sv
// ----------------------------------------------------------------------------
// kpd_out_buf
// Result register with a skid stage, so an item can be taken while the
// previous result is still waiting downstream.
// ----------------------------------------------------------------------------
module kpd_out_buf import kpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  kpd_result_t push_data,
  output logic        can_push,
  output logic        out_valid,
  input  logic        out_ready,
  output kpd_result_t out_data
);

  logic        main_v_r, main_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  kpd_result_t main_r, main_nxt;
  kpd_result_t skid_r, skid_nxt;
  logic        pop;

  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;
  assign pop       = main_v_r && out_ready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = push_data;
        main_v_nxt = push;
      end
    end else if (push) begin
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> rtl/core/keypad_scan_and_segment_display.sv
// ----------------------------------------------------------------------------
// keypad_scan_and_segment_display
// 4x4 keypad scanner sharing its column lines with a 4-digit 7-segment mux.
// ----------------------------------------------------------------------------
// Takes one item per clock while in.ready is high and returns one result per
// item. Scan and display state update at acceptance; the result lands in an
// output register backed by a one-entry skid stage, so in.ready only drops
// once two results are waiting. Reset shows "PEtE" and is ready to scan
// column 0 right away; there is no initialization pass.
module keypad_scan_and_segment_display import kpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  kpd_in_if.sink    in_ch,
  kpd_out_if.source out_ch
);

  kpd_item_t     item;
  kpd_scan_res_t scan_res;
  kpd_result_t   res;
  kpd_result_t   out_data;
  logic          accept;
  logic          can_push;
  logic [7:0]    segments;

  assign item.operation = in_ch.operation;
  assign item.char_code = in_ch.char_code;
  assign item.row_bits  = in_ch.row_bits;

  assign in_ch.ready = can_push;
  assign accept      = in_ch.valid && can_push;

  kpd_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .res    (scan_res)
  );

  kpd_display u_display (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (item),
    .column   (scan_res.column),
    .segments (segments)
  );

  always_comb begin
    res.column_select   = 4'(1) << scan_res.column;
    res.segment_pattern = segments;
    res.key_status      = scan_res.status;
    res.key_code        = scan_res.code;
  end

  kpd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.column_select   = out_data.column_select;
  assign out_ch.segment_pattern = out_data.segment_pattern;
  assign out_ch.key_status      = out_data.key_status;
  assign out_ch.key_code        = out_data.key_code;

endmodule
